/* hw/rtl/multichannel_conv1d_defines.svh */
// Assertion macros for the conv1d block. Each use names its own label.
// The enclosing module supplies clk and rst.
`ifndef MULTICHANNEL_CONV1D_DEFINES_SVH
`define MULTICHANNEL_CONV1D_DEFINES_SVH
`ifndef SYNTHESIS
`define MC1D_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MC1D_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MC1D_ASSERT_IMPL(label, ante, cons, msg)
`define MC1D_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* hw/rtl/mc1d_pkg.sv */
package mc1d_pkg;

  localparam int IN_CH_DEF  = 2;
  localparam int OUT_CH_DEF = 32;
  localparam int K_MAX_DEF  = 16;

  localparam int VALUE_W    = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 48;
  localparam int RCH_W      = 5;
  localparam int WOC_W      = 5;
  localparam int WTAP_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int NIN_REG_W  = 2;
  localparam int NOUT_REG_W = 6;
  localparam int TAPS_REG_W = 5;
  localparam int STEPS_W    = 5;
  localparam int STEPS_SAT  = 31;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IN_CH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS    = 2'd2;

  // bits needed to index n entries (at least one)
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int taps_max(input int k);
    return (k < STEPS_SAT) ? k : STEPS_SAT;
  endfunction

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             step_last;
    logic [RCH_W-1:0] chan;
  } mac_tag_t;

endpackage

/* hw/rtl/mc1d_wstore.sv */
module mc1d_wstore #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        waddr,
  input  logic signed [mc1d_pkg::VALUE_W-1:0]  wdata,
  input  logic                                 re,
  input  logic [AW-1:0]                        raddr,
  output logic signed [mc1d_pkg::VALUE_W-1:0]  rdata
);
  import mc1d_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/mc1d_hist.sv */
module mc1d_hist #(
  parameter int IN_CH = 2,
  parameter int K_MAX = 16
) (
  input  logic                                            clk,
  input  logic                                            shift_en,
  input  logic                                            shift_ch,
  input  logic signed [mc1d_pkg::VALUE_W-1:0]             shift_val,
  input  logic                                            rd_en,
  input  logic [mc1d_pkg::idx_w(IN_CH)-1:0]               rd_ch,
  input  logic [mc1d_pkg::idx_w(K_MAX)-1:0]               rd_idx,
  output logic signed [mc1d_pkg::VALUE_W-1:0]             rd_data
);
  import mc1d_pkg::*;

  // one shift line per input channel, newest sample at the top end
  logic signed [VALUE_W-1:0] line [IN_CH][K_MAX];

  always_ff @(posedge clk) begin
    for (int c = 0; c < IN_CH; c++) begin
      if (shift_en && (int'(shift_ch) == c)) begin
        for (int k = 0; k < K_MAX - 1; k++) begin
          line[c][k] <= line[c][k+1];
        end
        line[c][K_MAX-1] <= shift_val;
      end
    end
    if (rd_en) begin
      rd_data <= line[rd_ch][rd_idx];
    end
  end

endmodule

/* hw/rtl/mc1d_seq.sv */
`include "multichannel_conv1d_defines.svh"

module mc1d_seq #(
  parameter int IN_CH  = 2,
  parameter int OUT_CH = 32,
  parameter int K_MAX  = 16
) (
  input  logic                                                        clk,
  input  logic                                                        rst,
  input  logic                                                        in_accept,
  input  logic                                                        op,
  input  logic                                                        channel_index,
  input  logic                                                        sequence_start,
  input  logic [mc1d_pkg::idx_w(IN_CH+1)-1:0]                         nin,
  input  logic [mc1d_pkg::idx_w(OUT_CH+1)-1:0]                        nout,
  input  logic [mc1d_pkg::idx_w(mc1d_pkg::taps_max(K_MAX)+1)-1:0]     taps,
  input  logic                                                        adv,
  output logic                                                        hist_shift,
  output logic                                                        running,
  output mc1d_pkg::mac_tag_t                                          tag0,
  output logic [mc1d_pkg::idx_w(OUT_CH*IN_CH*K_MAX)-1:0]              waddr,
  output logic [mc1d_pkg::idx_w(IN_CH)-1:0]                           hist_ch,
  output logic [mc1d_pkg::idx_w(K_MAX)-1:0]                           hist_idx
);
  import mc1d_pkg::*;

  localparam int OC_W = idx_w(OUT_CH);
  localparam int CI_W = idx_w(IN_CH);
  localparam int T_W  = idx_w(K_MAX);
  localparam int WA_W = idx_w(OUT_CH * IN_CH * K_MAX);

  seq_state_t state, state_next;
  logic [OC_W-1:0]    oc;
  logic [CI_W-1:0]    ci;
  logic [T_W-1:0]     t;
  logic [STEPS_W-1:0] steps, steps_base, steps_next;
  logic               closes, go, t_last, ci_last, oc_last;

  // step bookkeeping on each accepted sample
  always_comb begin
    hist_shift = in_accept && (op == OP_SAMPLE) && (int'(channel_index) < int'(nin));
    closes     = hist_shift && (int'(channel_index) == int'(nin) - 1);
    steps_base = sequence_start ? '0 : steps;
    steps_next = steps_base;
    if (closes && (int'(steps_base) != STEPS_SAT)) begin
      steps_next = steps_base + 1'b1;
    end
    go = closes && (int'(steps_next) >= int'(taps));
  end

  assign t_last  = (int'(t) == int'(taps) - 1);
  assign ci_last = (int'(ci) == int'(nin) - 1);
  assign oc_last = (int'(oc) == int'(nout) - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (adv && t_last && ci_last && oc_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    running        = (state == ST_RUN);
    tag0.valid     = running;
    tag0.first     = (ci == '0) && (t == '0);
    tag0.last      = ci_last && t_last;
    tag0.step_last = ci_last && t_last && oc_last;
    tag0.chan      = RCH_W'(oc);
    waddr          = WA_W'((int'(oc) * IN_CH + int'(ci)) * K_MAX + int'(t));
    hist_ch        = ci;
    hist_idx       = T_W'(K_MAX - int'(taps) + int'(t));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      steps <= '0;
      oc    <= '0;
      ci    <= '0;
      t     <= '0;
    end else begin
      state <= state_next;
      if (hist_shift) steps <= steps_next;
      if (go) begin
        oc <= '0;
        ci <= '0;
        t  <= '0;
      end else if (running && adv) begin
        if (t_last) begin
          t <= '0;
          if (ci_last) begin
            ci <= '0;
            oc <= oc + 1'b1;
          end else begin
            ci <= ci + 1'b1;
          end
        end else begin
          t <= t + 1'b1;
        end
      end
    end
  end

  `MC1D_ASSERT_IMPL(a_go_when_idle, go, state == ST_IDLE, "step started while busy")
  `MC1D_ASSERT_IMPL(a_cnt_range, state == ST_RUN, (int'(oc) < int'(nout)) && (int'(ci) < int'(nin)) && (int'(t) < int'(taps)), "loop counter out of range")

endmodule

/* hw/rtl/mc1d_mac.sv */
`include "multichannel_conv1d_defines.svh"

module mc1d_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mc1d_pkg::mac_tag_t                   tag0,
  input  logic signed [mc1d_pkg::VALUE_W-1:0]  weight,
  input  logic signed [mc1d_pkg::VALUE_W-1:0]  sample,
  output logic                                 adv,
  output logic                                 busy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mc1d_pkg::RCH_W-1:0]           result_channel,
  output logic signed [mc1d_pkg::ACC_W-1:0]    result_value,
  output logic                                 last_of_step
);
  import mc1d_pkg::*;

  mac_tag_t                tag1, tag2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, sum;

  // whole pipeline freezes while an untaken word sits in the output register
  assign adv  = !out_valid || !out_stall;
  assign busy = tag1.valid || tag2.valid;
  assign sum  = (tag2.first ? '0 : acc) + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= weight * sample;
      if (tag2.valid) acc <= sum;
      if (tag2.valid && tag2.last) begin
        result_channel <= tag2.chan;
        result_value   <= sum;
        last_of_step   <= tag2.step_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1      <= '0;
      tag2      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      tag1      <= tag0;
      tag2      <= tag1;
      out_valid <= tag2.valid && tag2.last;
    end
  end

  `MC1D_ASSERT_IMPL(a_step_last_ends_sum, tag2.valid && tag2.step_last, tag2.last, "step end not on a sum end")
  `MC1D_ASSERT_NXT(a_freeze, !adv, $stable(tag2) && $stable(tag1), "pipeline moved while frozen")

endmodule

/* hw/rtl/multichannel_conv1d.sv */
// Valid-mode multichannel 1D convolution with Q1.15 weights and samples and
// exact 48-bit Q18.30 sums. A weight word or a sample that does not complete a
// step causes no stall. A sample that completes a step (once taps_used steps
// are in the history) makes the block stall its input while it works through
// every output channel, input channel and tap and then drains its pipeline:
// every product goes through one shared 16x16 multiplier and 48-bit
// accumulator at one per cycle while the output is not stalled, fed by one
// read of the weight RAM and one read of the sample history per cycle. The
// output side stalling freezes the whole pipeline.
// Sums come out in output channel order, last_of_step marks the final one.
// Weight RAM and sample history are not cleared by reset.
module multichannel_conv1d #(
  parameter int IN_CH  = mc1d_pkg::IN_CH_DEF,
  parameter int OUT_CH = mc1d_pkg::OUT_CH_DEF,
  parameter int K_MAX  = mc1d_pkg::K_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   op,
  input  logic [mc1d_pkg::WOC_W-1:0]             weight_out_channel,
  input  logic                                   channel_index,
  input  logic [mc1d_pkg::WTAP_W-1:0]            weight_tap,
  input  logic signed [mc1d_pkg::VALUE_W-1:0]    value,
  input  logic                                   sequence_start,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mc1d_pkg::RCH_W-1:0]             result_channel,
  output logic signed [mc1d_pkg::ACC_W-1:0]      result_value,
  output logic                                   last_of_step,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mc1d_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mc1d_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import mc1d_pkg::*;

  localparam int DEPTH  = OUT_CH * IN_CH * K_MAX;
  localparam int WA_W   = idx_w(DEPTH);
  localparam int CI_W   = idx_w(IN_CH);
  localparam int T_W    = idx_w(K_MAX);
  localparam int TMAX   = taps_max(K_MAX);
  localparam int NIN_W  = idx_w(IN_CH + 1);
  localparam int NOUT_W = idx_w(OUT_CH + 1);
  localparam int TAPS_W = idx_w(TMAX + 1);

  logic [NIN_REG_W-1:0]  in_channels_used;
  logic [NOUT_REG_W-1:0] out_channels_used;
  logic [TAPS_REG_W-1:0] taps_used;
  logic [NIN_W-1:0]      nin;
  logic [NOUT_W-1:0]     nout;
  logic [TAPS_W-1:0]     taps;

  logic                      in_accept, w_we, hist_shift, running, adv, mac_busy;
  logic [WA_W-1:0]           w_waddr, w_raddr;
  logic [CI_W-1:0]           hist_ch;
  logic [T_W-1:0]            hist_idx;
  logic signed [VALUE_W-1:0] w_rdata, h_rdata;
  mac_tag_t                  tag0;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_channels_used  <= NIN_REG_W'(2);
      out_channels_used <= NOUT_REG_W'(32);
      taps_used         <= TAPS_REG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_CH:  in_channels_used  <= cfg_data[NIN_REG_W-1:0];
        REG_OUT_CH: out_channels_used <= cfg_data[NOUT_REG_W-1:0];
        REG_TAPS:   taps_used         <= cfg_data[TAPS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to what the hardware holds; zero acts as one
  always_comb begin
    if (in_channels_used == '0) nin = NIN_W'(1);
    else if (int'(in_channels_used) > IN_CH) nin = NIN_W'(IN_CH);
    else nin = NIN_W'(in_channels_used);

    if (out_channels_used == '0) nout = NOUT_W'(1);
    else if (int'(out_channels_used) > OUT_CH) nout = NOUT_W'(OUT_CH);
    else nout = NOUT_W'(out_channels_used);

    if (taps_used == '0) taps = TAPS_W'(1);
    else if (int'(taps_used) > TMAX) taps = TAPS_W'(TMAX);
    else taps = TAPS_W'(taps_used);
  end

  assign in_stall  = running || mac_busy;
  assign in_accept = in_valid && !in_stall;

  assign w_we = in_accept && (op == OP_WEIGHT) && (int'(weight_out_channel) < OUT_CH)
                && (int'(channel_index) < IN_CH) && (int'(weight_tap) < K_MAX);
  assign w_waddr = WA_W'((int'(weight_out_channel) * IN_CH + int'(channel_index)) * K_MAX
                         + int'(weight_tap));

  mc1d_seq #(
    .IN_CH (IN_CH),
    .OUT_CH(OUT_CH),
    .K_MAX (K_MAX)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_accept     (in_accept),
    .op            (op),
    .channel_index (channel_index),
    .sequence_start(sequence_start),
    .nin           (nin),
    .nout          (nout),
    .taps          (taps),
    .adv           (adv),
    .hist_shift    (hist_shift),
    .running       (running),
    .tag0          (tag0),
    .waddr         (w_raddr),
    .hist_ch       (hist_ch),
    .hist_idx      (hist_idx)
  );

  mc1d_wstore #(
    .DEPTH(DEPTH),
    .AW   (WA_W)
  ) u_wstore (
    .clk  (clk),
    .we   (w_we),
    .waddr(w_waddr),
    .wdata(value),
    .re   (adv),
    .raddr(w_raddr),
    .rdata(w_rdata)
  );

  mc1d_hist #(
    .IN_CH(IN_CH),
    .K_MAX(K_MAX)
  ) u_hist (
    .clk      (clk),
    .shift_en (hist_shift),
    .shift_ch (channel_index),
    .shift_val(value),
    .rd_en    (adv),
    .rd_ch    (hist_ch),
    .rd_idx   (hist_idx),
    .rd_data  (h_rdata)
  );

  mc1d_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .tag0          (tag0),
    .weight        (w_rdata),
    .sample        (h_rdata),
    .adv           (adv),
    .busy          (mac_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_channel(result_channel),
    .result_value  (result_value),
    .last_of_step  (last_of_step)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import mc1d_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD   = 1500;
  localparam int KTAPS       = (K_MAX_DEF < STEPS_SAT) ? K_MAX_DEF : STEPS_SAT;

  typedef struct packed {
    logic                      op;
    logic [WOC_W-1:0]          woc;
    logic                      ch;
    logic [WTAP_W-1:0]         tap;
    logic signed [VALUE_W-1:0] val;
    logic                      start;
  } conv_word_t;

  typedef struct packed {
    logic [RCH_W-1:0]        chan;
    logic signed [ACC_W-1:0] sum;
    logic                    last;
  } conv_sum_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    conv_word_t              word;
    bit                      typed;
    logic signed [ACC_W-1:0] sum;
  } dir_row_t;

  typedef enum logic [1:0] {STALL_OFF, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = 1'b0;
  logic [WOC_W-1:0] weight_out_channel = '0;
  logic channel_index = 1'b0;
  logic [WTAP_W-1:0] weight_tap = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic sequence_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RCH_W-1:0] result_channel;
  logic signed [ACC_W-1:0] result_value;
  logic last_of_step;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  multichannel_conv1d u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .op                 (op),
    .weight_out_channel (weight_out_channel),
    .channel_index      (channel_index),
    .weight_tap         (weight_tap),
    .value              (value),
    .sequence_start     (sequence_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .result_channel     (result_channel),
    .result_value       (result_value),
    .last_of_step       (last_of_step),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // shadow copy of the block: registers, weight store, sample lines
  logic [NIN_REG_W-1:0]      set_nin  = NIN_REG_W'(IN_CH_DEF);
  logic [NOUT_REG_W-1:0]     set_nout = NOUT_REG_W'(OUT_CH_DEF);
  logic [TAPS_REG_W-1:0]     set_taps = TAPS_REG_W'(K_MAX_DEF);
  logic signed [VALUE_W-1:0] w_mem [OUT_CH_DEF][IN_CH_DEF][K_MAX_DEF];
  logic signed [VALUE_W-1:0] hist [IN_CH_DEF][K_MAX_DEF];
  int unsigned               steps_seen = 0;

  conv_sum_t sums_due[$];
  conv_sum_t new_sums[$];
  dir_row_t  dir_rows[$];

  int  errors = 0;
  int  cycle_cnt = 0;
  int  sums_checked = 0;
  int  words_taken = 0;
  int  rand_words = 0;
  int  rand_sums = 0;
  int  reg_writes = 0;
  int  long_holds = 0;
  int  burst_left = 0;
  bit  in_random = 1'b0;
  bit  hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= 20) $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
  endtask

  function automatic int eff_nin();
    if (set_nin == 0) return 1;
    return (set_nin > IN_CH_DEF) ? IN_CH_DEF : int'(set_nin);
  endfunction

  function automatic int eff_nout();
    if (set_nout == 0) return 1;
    return (set_nout > OUT_CH_DEF) ? OUT_CH_DEF : int'(set_nout);
  endfunction

  function automatic int eff_taps();
    if (set_taps == 0) return 1;
    return (set_taps > KTAPS) ? KTAPS : int'(set_taps);
  endfunction

  // Update the shadow state for one accepted word and leave the sums it
  // causes in new_sums. Returns 0 when the block ignores the word.
  function automatic bit conv_update(input conv_word_t w);
    int nin, nout, taps, i, oc, ci, t;
    longint acc;
    conv_sum_t s;
    nin  = eff_nin();
    nout = eff_nout();
    taps = eff_taps();
    new_sums.delete();
    if (w.op == OP_WEIGHT) begin
      w_mem[w.woc][w.ch][w.tap] = w.val;
      return 1'b1;
    end
    if (w.ch >= nin) return 1'b0;
    if (w.start) steps_seen = 0;
    for (i = 0; i < K_MAX_DEF - 1; i++) hist[w.ch][i] = hist[w.ch][i+1];
    hist[w.ch][K_MAX_DEF-1] = w.val;
    if (w.ch != nin - 1) return 1'b1;
    if (steps_seen < STEPS_SAT) steps_seen++;
    if (steps_seen < taps) return 1'b1;
    for (oc = 0; oc < nout; oc++) begin
      acc = 0;
      for (ci = 0; ci < nin; ci++)
        for (t = 0; t < taps; t++)
          acc += longint'(hist[ci][K_MAX_DEF-taps+t]) * longint'(w_mem[oc][ci][t]);
      s.chan = RCH_W'(oc);
      s.sum  = acc[ACC_W-1:0];
      s.last = (oc == nout - 1);
      new_sums.push_back(s);
    end
    return 1'b1;
  endfunction

  function automatic conv_word_t sample_word(input logic ch, input logic signed [15:0] v,
                                             input logic start);
    conv_word_t w;
    w = '0;
    w.op = OP_SAMPLE;
    w.ch = ch;
    w.val = v;
    w.start = start;
    return w;
  endfunction

  function automatic conv_word_t weight_word(input int oc, input int ch, input int tap,
                                             input logic signed [15:0] v);
    conv_word_t w;
    w = '0;
    w.op = OP_WEIGHT;
    w.woc = WOC_W'(oc);
    w.ch = ch[0];
    w.tap = WTAP_W'(tap);
    w.val = v;
    // fields unused by a weight write still toggle
    w.start = $urandom_range(0, 1);
    return w;
  endfunction

  function automatic logic signed [15:0] rand_q15();
    int r;
    logic [31:0] u;
    r = $urandom_range(0, 9);
    u = $urandom;
    case (r)
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return u[15:0];
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{ROW_CFG, idx, data, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t word_row(input conv_word_t w);
    dir_row_t r;
    r = '{ROW_WORD, '0, '0, w, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t typed_row(input conv_word_t w,
                                         input logic signed [ACC_W-1:0] sum);
    dir_row_t r;
    r = '{ROW_WORD, '0, '0, w, 1'b1, sum};
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_word(input conv_word_t w, input bit typed = 1'b0,
                           input logic signed [ACC_W-1:0] typed_sum = '0);
    int gap;
    conv_sum_t s;
    in_valid <= 1'b1;
    op <= w.op;
    weight_out_channel <= w.woc;
    channel_index <= w.ch;
    weight_tap <= w.tap;
    value <= w.val;
    sequence_start <= w.start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (conv_update(w)) begin
      words_taken++;
      if (in_random) rand_words++;
    end
    if (typed) begin
      s.chan = '0;
      s.sum  = typed_sum;
      s.last = 1'b1;
      sums_due.push_back(s);
    end else begin
      foreach (new_sums[i]) sums_due.push_back(new_sums[i]);
      if (in_random) rand_sums += new_sums.size();
    end
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  // Hold the input until every expected sum is out and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (sums_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IN_CH:  set_nin  = data[NIN_REG_W-1:0];
      REG_OUT_CH: set_nout = data[NOUT_REG_W-1:0];
      REG_TAPS:   set_taps = data[TAPS_REG_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One sequence of time steps, channels in order, with some noise mixed in.
  task automatic run_sequence(input int steps, input bit with_start);
    int nin, s, c, r;
    logic start;
    nin = eff_nin();
    for (s = 0; s < steps; s++) begin
      for (c = 0; c < nin; c++) begin
        r = $urandom_range(0, 99);
        start = with_start && s == 0 && c == 0;
        if (r < 8) begin
          send_word(weight_word($urandom_range(0, 31), $urandom_range(0, 1),
                                $urandom_range(0, 15), rand_q15()));
        end else if (r < 12) begin
          send_word(sample_word(c[0], rand_q15(), start));   // repeated channel
        end else if (r < 15 && c == 0 && nin == 2) begin
          continue;                                         // skipped channel
        end else if (r < 18 && nin == 1) begin
          send_word(sample_word(1'b1, rand_q15(), $urandom_range(0, 1)));
        end
        if (r >= 97) start = 1'b1;
        send_word(sample_word(c[0], rand_q15(), start));
      end
    end
  endtask

  always @(posedge clk) begin : check_sums
    conv_sum_t e;
    if (!rst && out_valid && !out_stall) begin
      if (sums_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected sum ch %0d value %0d", result_channel, result_value));
      end else begin
        e = sums_due.pop_front();
        sums_checked++;
        if (result_channel !== e.chan)
          flag_mismatch($sformatf("result_channel %0d, expected %0d", result_channel, e.chan));
        if (result_value !== e.sum)
          flag_mismatch($sformatf("result_value %0d, expected %0d (ch %0d)",
                                  result_value, e.sum, e.chan));
        if (last_of_step !== e.last)
          flag_mismatch($sformatf("last_of_step %0b, expected %0b (ch %0d)",
                                  last_of_step, e.last, e.chan));
      end
    end
  end

  // output side back-pressure
  stall_mode_e stall_mode = STALL_OFF;
  int mode_left = 0;
  int hold_left = 0;
  int period_cnt = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      long_holds++;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      period_cnt++;
      case (stall_mode)
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 35);
        STALL_PERIODIC: out_stall <= (period_cnt % 4 == 0);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  initial begin : stimulus
    int oc, ci, tp, s, phase_no;
    logic [CFG_DATA_W-1:0] d_nin, d_nout, d_taps;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the whole weight store, then fill both sample lines
    for (oc = 0; oc < OUT_CH_DEF; oc++)
      for (ci = 0; ci < IN_CH_DEF; ci++)
        for (tp = 0; tp < K_MAX_DEF; tp++)
          send_word(weight_word(oc, ci, tp, rand_q15()));
    for (s = 0; s < K_MAX_DEF; s++)
      for (ci = 0; ci < IN_CH_DEF; ci++)
        send_word(sample_word(ci[0], rand_q15(), s == 0 && ci == 0));

    // directed: clamping above range, channel order cases, zero settings, extremes
    dir_rows.push_back(cfg_row(REG_IN_CH, 6'd63));
    dir_rows.push_back(cfg_row(REG_OUT_CH, 6'd63));
    dir_rows.push_back(cfg_row(REG_TAPS, 6'd31));
    dir_rows.push_back(word_row(sample_word(1'b0, 16'sd32767, 1'b0)));
    dir_rows.push_back(word_row(sample_word(1'b1, -16'sd32768, 1'b0)));
    dir_rows.push_back(word_row(sample_word(1'b1, -16'sd1, 1'b0)));
    dir_rows.push_back(word_row(sample_word(1'b0, 16'sd100, 1'b0)));
    dir_rows.push_back(word_row(sample_word(1'b0, -16'sd100, 1'b0)));
    dir_rows.push_back(word_row(sample_word(1'b1, 16'sd0, 1'b0)));
    dir_rows.push_back(word_row(weight_word(31, 1, 15, -16'sd32768)));
    dir_rows.push_back(word_row(sample_word(1'b0, 16'sd7, 1'b1)));
    dir_rows.push_back(word_row(sample_word(1'b1, -16'sd7, 1'b0)));
    dir_rows.push_back(cfg_row(REG_IN_CH, 6'd0));
    dir_rows.push_back(cfg_row(REG_OUT_CH, 6'd0));
    dir_rows.push_back(cfg_row(REG_TAPS, 6'd0));
    dir_rows.push_back(word_row(weight_word(0, 0, 0, -16'sd32768)));
    dir_rows.push_back(typed_row(sample_word(1'b0, -16'sd32768, 1'b0), 48'sd1073741824));
    dir_rows.push_back(typed_row(sample_word(1'b0, 16'sd32767, 1'b0), -48'sd1073709056));
    dir_rows.push_back(word_row(sample_word(1'b1, 16'sd555, 1'b1)));
    dir_rows.push_back(word_row(weight_word(0, 0, 0, 16'sd32767)));
    dir_rows.push_back(typed_row(sample_word(1'b0, 16'sd32767, 1'b0), 48'sd1073676289));
    dir_rows.push_back(typed_row(sample_word(1'b0, 16'sd0, 1'b1), 48'sd0));
    dir_rows.push_back(word_row(weight_word(0, 1, 0, 16'sd12345)));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) cfg_write(dir_rows[i].idx, dir_rows[i].data);
      else send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].sum);
    end

    // random phases, each under its own register setting
    in_random = 1'b1;
    phase_no = 0;
    while (rand_words < 240 || rand_sums < 48) begin
      case (phase_no)
        1: begin d_nin = 6'd1; d_nout = 6'd8;  d_taps = 6'd1;  end   // long output hold
        2: begin d_nin = 6'd2; d_nout = 6'd2;  d_taps = 6'd3;  end   // step count saturates
        3: begin d_nin = 6'd3; d_nout = 6'd63; d_taps = 6'd17; end
        4: begin d_nin = 6'd0; d_nout = 6'd0;  d_taps = 6'd0;  end
        default: begin
          d_nin  = $urandom_range(0, 3);
          d_nout = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 63) : $urandom_range(0, 8);
          d_taps = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 31) : $urandom_range(0, 5);
        end
      endcase
      cfg_write(REG_IN_CH, d_nin);
      cfg_write(REG_OUT_CH, d_nout);
      cfg_write(REG_TAPS, d_taps);
      if (phase_no == 1) begin
        hold_req = 1'b1;
        run_sequence(24, 1'b1);
      end else if (phase_no == 2) begin
        run_sequence(40, 1'b1);
      end else begin
        repeat ($urandom_range(1, 3))
          run_sequence(eff_taps() + $urandom_range(0, 3), $urandom_range(0, 9) != 0);
      end
      phase_no++;
    end

    wait_idle();
    repeat (16) @(negedge clk);
    $display("run: %0d words taken (%0d random), %0d register writes over %0d phases",
             words_taken, rand_words, reg_writes, phase_no);
    $display("run: %0d sums checked, %0d long output holds, %0d mismatches",
             sums_checked, long_holds, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mc1d_pkg.sv
hw/rtl/mc1d_wstore.sv
hw/rtl/mc1d_hist.sv
hw/rtl/mc1d_seq.sv
hw/rtl/mc1d_mac.sv
hw/rtl/multichannel_conv1d.sv
dv/tb_top.sv
